[rtl/core/lfl_pkg.sv]
// Shared types and constants for the linked free-list slot pool.
`timescale 1ns / 1ps
`default_nettype none

package lfl_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 32;
  localparam int unsigned NUM_W          = 5;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_BAD_VALUE  = 2'd2,
    ST_NOT_ACTIVE = 2'd3
  } lfl_status_e;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_ALLOC_BAD = 2'd1,
    OP_RELEASE   = 2'd2
  } lfl_op_e;

  typedef struct packed {
    logic               command;
    logic [NUM_W-1:0]   slot_number;
    logic [VALUE_W-1:0] value;
    logic               value_ok;
  } lfl_in_t;

  typedef struct packed {
    lfl_status_e      status;
    logic [NUM_W-1:0] granted_number;
  } lfl_out_t;

  typedef struct packed {
    lfl_op_e            op;
    logic [NUM_W-1:0]   target;
    logic [VALUE_W-1:0] value;
  } lfl_op_t;

endpackage

`default_nettype wire

[rtl/core/lfl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lfl_ram
  import lfl_pkg::*;
#(
  parameter int unsigned WIDTH = VALUE_W,
  parameter int unsigned DEPTH = DEF_SLOT_COUNT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/lfl_front.sv]
// Front end: accept commands, classify them and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module lfl_front
  import lfl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire lfl_in_t in_data_i,
  output logic         op_valid_o,
  input  wire logic    op_pop_i,
  output lfl_op_t      op_o
);

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  lfl_op_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  lfl_op_t             classified;
  logic                push, pop;

  // Classify: the free-slot check needs pool state, so a bad value is only tagged here.
  always_comb begin
    classified.target = in_data_i.slot_number;
    classified.value  = in_data_i.value;
    if (in_data_i.command == CMD_RELEASE) begin
      classified.op = OP_RELEASE;
    end else if (in_data_i.value_ok) begin
      classified.op = OP_ALLOC;
    end else begin
      classified.op = OP_ALLOC_BAD;
    end
  end

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign op_valid_o = (count_q != '0);
  assign op_o       = entry_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = op_pop_i && op_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= classified;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lfl_back.sv]
// Back end: list sequencer over the link and value stores, plus result register.
`timescale 1ns / 1ps
`default_nettype none

module lfl_back
  import lfl_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    op_valid_i,
  output logic         op_pop_o,
  input  wire lfl_op_t op_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output lfl_out_t     out_data_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned PTR_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CMP_W = (PTR_W > NUM_W) ? PTR_W : NUM_W;
  localparam logic [PTR_W-1:0] END_PTR = PTR_W'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_WALK  = 4'b0100,
    S_PUSH  = 4'b1000
  } lfl_state_e;

  lfl_state_e        state_q, state_d;
  logic [PTR_W-1:0]  free_head_q, free_head_d;
  logic [PTR_W-1:0]  active_head_q, active_head_d;
  logic [PTR_W-1:0]  cur_q, cur_d;
  logic [PTR_W-1:0]  prev_q, prev_d;
  logic [PTR_W-1:0]  steps_q, steps_d;
  logic [NUM_W-1:0]  target_q, target_d;
  logic [SLOT_COUNT-1:0] lvalid_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  rd_addr_q;
  logic              out_valid_q, out_valid_d;
  lfl_out_t          out_q, out_d;

  logic              link_re, link_we;
  logic [IDX_W-1:0]  link_raddr, link_waddr;
  logic [PTR_W-1:0]  link_wdata, link_ram_rdata, link_rd;
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr;
  logic [VALUE_W-1:0] val_wdata;

  logic              res_free, emit;
  lfl_out_t          res;
  logic [CMP_W-1:0]  free_ext, cur_ext, target_ext;

  lfl_ram #(
    .WIDTH(PTR_W),
    .DEPTH(SLOT_COUNT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (link_re),
    .raddr_i(link_raddr),
    .rdata_o(link_ram_rdata)
  );

  // Value store: written on allocate, cleared on release; never read back out.
  lfl_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(SLOT_COUNT)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

  // An entry never written still holds its reset link, the next slot up.
  assign link_rd = rd_valid_q ? link_ram_rdata : PTR_W'(rd_addr_q) + PTR_W'(1);

  assign free_ext   = CMP_W'(free_head_q);
  assign cur_ext    = CMP_W'(cur_q);
  assign target_ext = CMP_W'(target_q);
  assign res_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    free_head_d   = free_head_q;
    active_head_d = active_head_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    steps_d       = steps_q;
    target_d      = target_q;
    op_pop_o      = 1'b0;
    link_re       = 1'b0;
    link_raddr    = free_head_q[IDX_W-1:0];
    link_we       = 1'b0;
    link_waddr    = free_head_q[IDX_W-1:0];
    link_wdata    = active_head_q;
    val_we        = 1'b0;
    val_waddr     = free_head_q[IDX_W-1:0];
    val_wdata     = op_i.value;
    emit          = 1'b0;
    res.status         = ST_OK;
    res.granted_number = '0;

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i && res_free) begin
          op_pop_o = 1'b1;
          unique case (op_i.op)
            OP_ALLOC, OP_ALLOC_BAD: begin
              if (free_head_q >= END_PTR) begin
                emit       = 1'b1;
                res.status = ST_NO_FREE;
              end else if (op_i.op == OP_ALLOC_BAD) begin
                emit       = 1'b1;
                res.status = ST_BAD_VALUE;
              end else begin
                link_re = 1'b1;
                val_we  = 1'b1;
                state_d = S_ALLOC;
              end
            end
            OP_RELEASE: begin
              cur_d      = active_head_q;
              prev_d     = END_PTR;
              steps_d    = '0;
              target_d   = op_i.target;
              link_re    = 1'b1;
              link_raddr = active_head_q[IDX_W-1:0];
              state_d    = S_WALK;
            end
            default: begin
              emit       = 1'b1;
              res.status = ST_NOT_ACTIVE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // Pop the free head onto the active head.
        if (res_free) begin
          link_we            = 1'b1;
          free_head_d        = link_rd;
          active_head_d      = free_head_q;
          emit               = 1'b1;
          res.granted_number = free_ext[NUM_W-1:0];
          state_d            = S_IDLE;
        end
      end
      S_WALK: begin
        priority if (cur_q >= END_PTR || steps_q == END_PTR) begin
          if (res_free) begin
            emit       = 1'b1;
            res.status = ST_NOT_ACTIVE;
            state_d    = S_IDLE;
          end
        end else if (cur_ext == target_ext) begin
          // Unlink: bypass the hit in its predecessor or in the head.
          if (prev_q < END_PTR) begin
            link_we    = 1'b1;
            link_waddr = prev_q[IDX_W-1:0];
            link_wdata = link_rd;
          end else begin
            active_head_d = link_rd;
          end
          state_d = S_PUSH;
        end else begin
          prev_d     = cur_q;
          cur_d      = link_rd;
          steps_d    = steps_q + PTR_W'(1);
          link_re    = 1'b1;
          link_raddr = link_rd[IDX_W-1:0];
        end
      end
      S_PUSH: begin
        if (res_free) begin
          link_we            = 1'b1;
          link_waddr         = cur_q[IDX_W-1:0];
          link_wdata         = free_head_q;
          free_head_d        = cur_q;
          val_we             = 1'b1;
          val_waddr          = cur_q[IDX_W-1:0];
          val_wdata          = '0;
          emit               = 1'b1;
          res.granted_number = cur_ext[NUM_W-1:0];
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      free_head_q   <= '0;
      active_head_q <= END_PTR;
      lvalid_q      <= '0;
      rd_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      free_head_q   <= free_head_d;
      active_head_q <= active_head_d;
      out_valid_q   <= out_valid_d;
      if (link_we) begin
        lvalid_q[link_waddr] <= 1'b1;
      end
      if (link_re) begin
        rd_valid_q <= lvalid_q[link_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    steps_q  <= steps_d;
    target_q <= target_d;
    out_q    <= out_d;
    if (link_re) begin
      rd_addr_q <= link_raddr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_heads_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= END_PTR && active_head_q <= END_PTR)
    else $error("list head beyond end marker");

  a_alloc_pushes_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && res_free) |=> active_head_q == $past(free_head_q))
    else $error("allocated slot did not become active head");

  a_release_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && res_free) |=> free_head_q == $past(cur_q) && out_valid_q)
    else $error("released slot not pushed onto free list");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> steps_q <= END_PTR)
    else $error("walk ran past the pool size");

  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> state_q == S_IDLE && res_free)
    else $error("command taken while sequencer busy");

endmodule

`default_nettype wire

[rtl/core/linked_free_list_slot_pool.sv]
// Top level of the linked free-list slot pool.
//
// A pool of SLOT_COUNT numbered slots sits on two LIFO linked lists, free and
// active, which share one link RAM; reset puts every slot on the free list in
// ascending order. Each input beat is one command and yields exactly one
// result beat: an allocate pops the free head, stores the value and pushes the
// slot onto the active list (status ok and the slot number, or no-free /
// bad-value with number 0); a release searches the active list from its head,
// unlinks the slot, clears its value and pushes it onto the free list (status
// ok and the number, or not-active with number 0). A two-beat command queue
// sits between the front end and the list sequencer, and the result sits in
// an output register, so new commands are taken while a result waits.
// A refused allocate is answered when the sequencer takes it; a good allocate
// passes through the allocate state, and a release through the walk state,
// which visits each active-list entry ahead of the hit (on a miss, the whole
// list), then the push state. The walk is set by the link RAM read port,
// which follows one link per cycle. Entries of the link RAM that were never
// written read as their reset link through per-entry valid bits, so no
// clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module linked_free_list_slot_pool
  import lfl_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lfl_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lfl_out_t      out_data_o
);

  // Classified commands on their way from the front end to the sequencer.
  logic    op_valid;
  logic    op_pop;
  lfl_op_t op;

  // Accept and classify commands; hold them in the queue.
  lfl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .op_valid_o(op_valid),
    .op_pop_i  (op_pop),
    .op_o      (op)
  );

  // Carry out list operations and drive the result register.
  lfl_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .op_i       (op),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
